>>> hdl/w3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package w3_pkg;

  // digit width of the partial-product multipliers
  localparam int DIG_BITS = 32;
  localparam int EPS_BITS = 32;
  localparam int SAMPLE_BITS_DEF = 32;

endpackage

`default_nettype wire

>>> hdl/w3_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module w3_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int LN = 1,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [LN-1:0][AW-1:0]     a,
  input  logic [LN-1:0][BW-1:0]     b,
  input  logic [SW-1:0]             side,
  output logic                      out_valid,
  output logic [LN-1:0][AW+BW-1:0]  prod,
  output logic [SW-1:0]             side_out
);

  localparam int DG  = w3_pkg::DIG_BITS;
  localparam int NA  = (AW + DG - 1) / DG;
  localparam int NB  = (BW + DG - 1) / DG;
  localparam int NS  = NA * NB;
  localparam int AXW = NA * DG;
  localparam int BXW = NB * DG;
  localparam int EW  = AXW + BXW;

  logic [NS:0]                    vld;
  logic [NS:0][LN-1:0][AXW-1:0]   ap;
  logic [NS:0][LN-1:0][BXW-1:0]   bp;
  logic [NS:0][LN-1:0][EW-1:0]    acc;
  logic [NS:0][SW-1:0]            sd;
  logic [NS-1:0][LN-1:0][2*DG-1:0] pp;

  // one digit pair per stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      for (int l = 0; l < LN; l++) begin
        pp[k][l] = (2*DG)'(ap[k][l][(k / NB)*DG +: DG]) *
                   (2*DG)'(bp[k][l][(k % NB)*DG +: DG]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LN; l++) begin
      ap[0][l]  <= AXW'(a[l]);
      bp[0][l]  <= BXW'(b[l]);
      acc[0][l] <= '0;
    end
    sd[0] <= side;
    for (int k = 0; k < NS; k++) begin
      ap[k+1] <= ap[k];
      bp[k+1] <= bp[k];
      sd[k+1] <= sd[k];
      for (int l = 0; l < LN; l++) begin
        acc[k+1][l] <= acc[k][l] + (EW'(pp[k][l]) << ((k / NB + k % NB) * DG));
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      prod[l] = acc[NS][l][AW+BW-1:0];
    end
  end

  assign out_valid = vld[NS];
  assign side_out  = sd[NS];

endmodule

`default_nettype wire

>>> hdl/w3_div.sv
`timescale 1ns / 1ps
`default_nettype none

module w3_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QB = 32,
  parameter int LN = 1,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [LN-1:0][NW-1:0]  num,
  input  logic [LN-1:0][DW-1:0]  den,
  input  logic [SW-1:0]          side,
  output logic                   out_valid,
  output logic [LN-1:0][QB-1:0]  quo,
  output logic [SW-1:0]          side_out
);

  logic [QB:0]                  vld;
  logic [QB:0][LN-1:0][NW-1:0]  rem;
  logic [QB:0][LN-1:0][DW-1:0]  dv;
  logic [QB:0][LN-1:0][QB-1:0]  q;
  logic [QB:0][SW-1:0]          sd;
  logic [QB-1:0][LN-1:0][NW:0]  df;

  // restoring step, quotient msb first
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < LN; l++) begin
        df[k][l] = {1'b0, rem[k][l]} - {1'b0, NW'(dv[k][l]) << (QB - 1 - k)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem[0] <= num;
    dv[0]  <= den;
    q[0]   <= '0;
    sd[0]  <= side;
    for (int k = 0; k < QB; k++) begin
      dv[k+1] <= dv[k];
      sd[k+1] <= sd[k];
      for (int l = 0; l < LN; l++) begin
        rem[k+1][l] <= df[k][l][NW] ? rem[k][l] : df[k][l][NW-1:0];
        q[k+1][l]   <= {q[k][l][QB-2:0], ~df[k][l][NW]};
      end
    end
  end

  assign out_valid = vld[QB];
  assign quo       = q[QB];
  assign side_out  = sd[QB];

endmodule

`default_nettype wire

>>> hdl/weno3_face_reconstruct.sv
`timescale 1ns / 1ps
`default_nettype none

// throughput: one stencil per cycle, busy stays low; the long division is one quotient
//   bit per pipeline stage and the wide products one 32x32 digit pair per stage
// reset: synchronous, clears all valid bits and sets epsilon to 1; no results are dropped
//   since the receiver cannot stall
module weno3_face_reconstruct #(
  parameter int SAMPLE_BITS = w3_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [SAMPLE_BITS-1:0]        cell_oldest,
  input  logic [SAMPLE_BITS-1:0]        cell_middle,
  input  logic [SAMPLE_BITS-1:0]        cell_newest,
  input  logic                          eps_we,
  input  logic [w3_pkg::EPS_BITS-1:0]   eps_wdata,
  output logic                          done,
  output logic [SAMPLE_BITS-1:0]        left_face_value,
  output logic [SAMPLE_BITS-1:0]        right_face_value
);

  localparam int W   = SAMPLE_BITS;
  localparam int EB  = w3_pkg::EPS_BITS;
  localparam int TW  = 2*W + 1;
  localparam int QW  = 2*TW;
  localparam int PW  = QW + W;
  localparam int NMW = PW + 2;
  localparam int DNW = QW + 3;
  localparam int NNW = NMW + 2;
  localparam int DDW = DNW + 1;
  localparam int SW1 = 3*W + 4;
  localparam int SW3 = W + 4 + 2*DNW;
  localparam int SWD = W + 4;

  function automatic logic [W-1:0] face(input logic [W-1:0] mid, input logic [W-1:0] corr,
                                        input logic neg, input logic zero);
    logic [W+1:0] bx;
    logic [W+1:0] r;
    bx = {{2{mid[W-1]}}, mid};
    if (zero) begin
      r = bx;
    end else if (neg) begin
      r = bx - {2'b00, corr};
    end else begin
      r = bx + {2'b00, corr};
    end
    if (r[W+1] != r[W-1] || r[W] != r[W-1]) begin
      face = r[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      face = r[W-1:0];
    end
  endfunction

  logic [EB-1:0] eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EB'(1);
    end else if (eps_we) begin
      eps <= eps_wdata;
    end
  end

  assign busy = 1'b0;

  // stage 1: differences, magnitudes, signs for both faces
  logic [W:0]   dl0, dl1, ng0, ng1;
  logic         s1_vld;
  logic [W-1:0] s1_b, s1_m0, s1_m1;
  logic [3:0]   s1_sg;

  always_comb begin
    dl0 = {cell_middle[W-1], cell_middle} - {cell_oldest[W-1], cell_oldest};
    dl1 = {cell_newest[W-1], cell_newest} - {cell_middle[W-1], cell_middle};
    ng0 = (W+1)'(0) - dl0;
    ng1 = (W+1)'(0) - dl1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_b  <= cell_middle;
    s1_m0 <= dl0[W] ? ng0[W-1:0] : dl0[W-1:0];
    s1_m1 <= dl1[W] ? ng1[W-1:0] : dl1[W-1:0];
    // left: b<a, c<b; right: b<c, a<b
    s1_sg <= {~dl0[W] & (|dl0), ~dl1[W] & (|dl1), dl1[W], dl0[W]};
  end

  // squares of the differences
  logic               m1_vld;
  logic [1:0][2*W-1:0] m1_p;
  logic [SW1-1:0]     m1_sd;

  w3_mul #(.AW(W), .BW(W), .LN(2), .SW(SW1)) u_mul_sq (
    .clk(clk), .rst(rst), .in_valid(s1_vld),
    .a({s1_m1, s1_m0}), .b({s1_m1, s1_m0}),
    .side({s1_b, s1_m0, s1_m1, s1_sg}),
    .out_valid(m1_vld), .prod(m1_p), .side_out(m1_sd)
  );

  // stage 2: add bias
  logic           s2_vld;
  logic [TW-1:0]  s2_t0, s2_t1;
  logic [SW1-1:0] s2_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_t0 <= TW'(m1_p[0]) + TW'(eps);
    s2_t1 <= TW'(m1_p[1]) + TW'(eps);
    s2_sd <= m1_sd;
  end

  logic                m2_vld;
  logic [1:0][QW-1:0]  m2_p;
  logic [SW1-1:0]      m2_sd;

  w3_mul #(.AW(TW), .BW(TW), .LN(2), .SW(SW1)) u_mul_wt (
    .clk(clk), .rst(rst), .in_valid(s2_vld),
    .a({s2_t1, s2_t0}), .b({s2_t1, s2_t0}), .side(s2_sd),
    .out_valid(m2_vld), .prod(m2_p), .side_out(m2_sd)
  );

  // stage 3: denominators 2(A+B) per face
  logic [W-1:0]   m2_b, m2_m0, m2_m1;
  logic [3:0]     m2_sg;
  logic           s3_vld;
  logic [QW-1:0]  s3_q0, s3_q1;
  logic [W-1:0]   s3_b, s3_m0, s3_m1;
  logic [3:0]     s3_sg;
  logic [DNW-1:0] s3_dl, s3_dr;

  assign {m2_b, m2_m0, m2_m1, m2_sg} = m2_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s3_q0 <= m2_p[0];
    s3_q1 <= m2_p[1];
    s3_b  <= m2_b;
    s3_m0 <= m2_m0;
    s3_m1 <= m2_m1;
    s3_sg <= m2_sg;
    s3_dl <= (DNW'(m2_p[1]) + (DNW'(m2_p[0]) << 1)) << 1;
    s3_dr <= (DNW'(m2_p[0]) + (DNW'(m2_p[1]) << 1)) << 1;
  end

  // cross products: lane 0 q1*m0, lane 1 q0*m1
  logic               m3_vld;
  logic [1:0][PW-1:0] m3_p;
  logic [SW3-1:0]     m3_sd;

  w3_mul #(.AW(QW), .BW(W), .LN(2), .SW(SW3)) u_mul_nm (
    .clk(clk), .rst(rst), .in_valid(s3_vld),
    .a({s3_q0, s3_q1}), .b({s3_m1, s3_m0}),
    .side({s3_b, s3_sg, s3_dl, s3_dr}),
    .out_valid(m3_vld), .prod(m3_p), .side_out(m3_sd)
  );

  // stage 4: signed numerators as sign and magnitude
  logic [W-1:0]   m3_b;
  logic [3:0]     m3_sg;
  logic [DNW-1:0] m3_dl, m3_dr;
  logic [NMW-1:0] pl, sl, pr, sr, mag_l, mag_r;
  logic           neg_l, neg_r;
  logic           s4_vld;
  logic [NMW-1:0] s4_ml, s4_mr;
  logic           s4_nl, s4_nr;
  logic [W-1:0]   s4_b;
  logic [DNW-1:0] s4_dl, s4_dr;

  assign {m3_b, m3_sg, m3_dl, m3_dr} = m3_sd;

  always_comb begin
    pl = NMW'(m3_p[0]);
    sl = NMW'(m3_p[1]) << 1;
    pr = NMW'(m3_p[1]);
    sr = NMW'(m3_p[0]) << 1;
    if (m3_sg[0] == m3_sg[1]) begin
      mag_l = pl + sl;
      neg_l = m3_sg[0];
    end else if (pl >= sl) begin
      mag_l = pl - sl;
      neg_l = m3_sg[0];
    end else begin
      mag_l = sl - pl;
      neg_l = m3_sg[1];
    end
    if (m3_sg[2] == m3_sg[3]) begin
      mag_r = pr + sr;
      neg_r = m3_sg[2];
    end else if (pr >= sr) begin
      mag_r = pr - sr;
      neg_r = m3_sg[2];
    end else begin
      mag_r = sr - pr;
      neg_r = m3_sg[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_ml <= mag_l;
    s4_mr <= mag_r;
    s4_nl <= neg_l;
    s4_nr <= neg_r;
    s4_b  <= m3_b;
    s4_dl <= m3_dl;
    s4_dr <= m3_dr;
  end

  // stage 5: rounding offset, half away from zero
  logic           s5_vld;
  logic [NNW-1:0] s5_nl, s5_nr;
  logic [DDW-1:0] s5_dl, s5_dr;
  logic [W-1:0]   s5_b;
  logic           s5_gl, s5_gr, s5_zl, s5_zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_nl <= (NNW'(s4_ml) << 1) + NNW'(s4_dl);
    s5_nr <= (NNW'(s4_mr) << 1) + NNW'(s4_dr);
    s5_dl <= DDW'(s4_dl) << 1;
    s5_dr <= DDW'(s4_dr) << 1;
    s5_b  <= s4_b;
    s5_gl <= s4_nl;
    s5_gr <= s4_nr;
    s5_zl <= (s4_dl == '0);
    s5_zr <= (s4_dr == '0);
  end

  logic               dv_vld;
  logic [1:0][W-1:0]  dv_q;
  logic [SWD-1:0]     dv_sd;
  logic [W-1:0]       dv_b;
  logic               dv_gl, dv_gr, dv_zl, dv_zr;

  w3_div #(.NW(NNW), .DW(DDW), .QB(W), .LN(2), .SW(SWD)) u_div (
    .clk(clk), .rst(rst), .in_valid(s5_vld),
    .num({s5_nr, s5_nl}), .den({s5_dr, s5_dl}),
    .side({s5_b, s5_gl, s5_gr, s5_zl, s5_zr}),
    .out_valid(dv_vld), .quo(dv_q), .side_out(dv_sd)
  );

  assign {dv_b, dv_gl, dv_gr, dv_zl, dv_zr} = dv_sd;

  // stage 6: apply correction and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    left_face_value  <= face(dv_b, dv_q[0], dv_gl, dv_zl);
    right_face_value <= face(dv_b, dv_q[1], dv_gr, dv_zr);
  end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [31:0] oldest;
    logic [31:0] middle;
    logic [31:0] newest;
  } stencil_t;

  typedef struct packed {
    logic [31:0] left_v;
    logic [31:0] right_v;
  } faces_t;

  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [31:0] S_MAX = 32'h7fffffff;
  localparam logic [31:0] S_MIN = 32'h80000000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] cell_oldest;
  logic [31:0] cell_middle;
  logic [31:0] cell_newest;
  logic        eps_we;
  logic [31:0] eps_wdata;
  logic        done;
  logic [31:0] left_face_value;
  logic [31:0] right_face_value;

  stencil_t    stencil_q[$];
  faces_t      faces_q[$];
  logic [31:0] eps_shadow;
  int          mismatches;
  int          sent;
  int          stall_cycles;

  weno3_face_reconstruct dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cell_oldest(cell_oldest), .cell_middle(cell_middle), .cell_newest(cell_newest),
    .eps_we(eps_we), .eps_wdata(eps_wdata),
    .done(done), .left_face_value(left_face_value), .right_face_value(right_face_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one face of the blend, exact rational then rounded half away from zero
  function automatic logic [31:0] weno_face(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                            logic [31:0] eps);
    logic signed [33:0]  d0s, d1s;
    logic [399:0]        m0, m1, wa, wb, p, s, num, den, q;
    logic                n0, n1, neg;
    logic signed [127:0] val;
    d0s = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
    d1s = $signed({{2{c[31]}}, c}) - $signed({{2{b[31]}}, b});
    n0 = d0s < 0;
    n1 = d1s < 0;
    m0 = n0 ? 400'(-d0s) : 400'(d0s);
    m1 = n1 ? 400'(-d1s) : 400'(d1s);
    wa = (m1 * m1 + 400'(eps)) * (m1 * m1 + 400'(eps));
    wb = ((m0 * m0 + 400'(eps)) * (m0 * m0 + 400'(eps))) << 1;
    den = (wa + wb) << 1;
    if (den == 0) return b;
    p = wa * m0;
    s = wb * m1;
    if (n0 == n1) begin
      num = p + s;
      neg = n0;
    end else if (p >= s) begin
      num = p - s;
      neg = n0;
    end else begin
      num = s - p;
      neg = n1;
    end
    q = ((num << 1) + den) / (den << 1);
    val = neg ? $signed(128'($signed(b))) - $signed(q[127:0])
              : $signed(128'($signed(b))) + $signed(q[127:0]);
    if (val > $signed(128'($signed(S_MAX)))) return S_MAX;
    if (val < $signed(128'($signed(S_MIN)))) return S_MIN;
    return val[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // driver: one request per cycle at most, random idling outside the quiet stretch
  always @(posedge clk) begin
    stencil_t nxt;
    if (rst) begin
      start <= 1'b0;
      cell_oldest <= '0;
      cell_middle <= '0;
      cell_newest <= '0;
    end else begin
      if (start && !busy) begin
        faces_q.push_back('{weno_face(cell_oldest, cell_middle, cell_newest, eps_shadow),
                            weno_face(cell_newest, cell_middle, cell_oldest, eps_shadow)});
        sent++;
      end
      if (!start || !busy) begin
        if (stencil_q.size() > 0 && ((sent > 400 && sent < 750) || $urandom_range(99) >= 26))
        begin
          nxt = stencil_q.pop_front();
          cell_oldest <= nxt.oldest;
          cell_middle <= nxt.middle;
          cell_newest <= nxt.newest;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    faces_t want;
    if (!rst && done) begin
      if (faces_q.size() == 0) begin
        report_mismatch("unexpected result", left_face_value, 'x);
      end else begin
        want = faces_q.pop_front();
        if (left_face_value !== want.left_v)
          report_mismatch("left_face_value", left_face_value, want.left_v);
        if (right_face_value !== want.right_v)
          report_mismatch("right_face_value", right_face_value, want.right_v);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_stencil(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    stencil_q.push_back('{a, b, c});
  endtask

  task automatic add_random(int count);
    logic [31:0] b;
    int          kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      b = $urandom;
      if (kind < 5) begin
        // smooth data with small local differences
        add_stencil(b + 32'($signed($urandom_range(4000)) - 2000), b,
                    b + 32'($signed($urandom_range(4000)) - 2000));
      end else if (kind < 7) begin
        // discontinuity next to one side
        if ($urandom_range(1))
          add_stencil(b + 32'($urandom_range(400)), b, $urandom);
        else
          add_stencil($urandom, b, b - 32'($urandom_range(400)));
      end else if (kind == 7) begin
        add_stencil($urandom_range(1) ? S_MAX - 32'($urandom_range(3)) : S_MIN + $urandom_range(3),
                    $urandom, $urandom_range(1) ? S_MAX : S_MIN);
      end else begin
        add_stencil($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic settle_and_set_eps(logic [31:0] value);
    while (stencil_q.size() > 0 || start || faces_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    eps_shadow = value;
    eps_we <= 1'b1;
    eps_wdata <= value;
    @(posedge clk);
    eps_we <= 1'b0;
  endtask

  task automatic add_directed();
    add_stencil(0, 0, 0);
    add_stencil(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_stencil(S_MIN, S_MAX, S_MIN);
    add_stencil(S_MAX, S_MIN, S_MAX);
    add_stencil(S_MIN, S_MAX, S_MAX);
    add_stencil(S_MAX, S_MIN, S_MIN);
    add_stencil(S_MIN, S_MIN, S_MAX);
    add_stencil(S_MAX, S_MAX, S_MIN);
    add_stencil(S_MAX, S_MAX, S_MAX);
    add_stencil(S_MIN, S_MIN, S_MIN);
    add_stencil(32'hffff_ffff, 0, 1);
    add_stencil(1, 0, 32'hffff_ffff);
    add_stencil(0, 1, 0);
    add_stencil(0, 32'hffff_ffff, 0);
    add_stencil(32'h4000_0000, 32'h7000_0000, 32'h7000_0001);
    add_stencil(32'hc000_0000, 32'h9000_0000, 32'h8fff_ffff);
    add_stencil(32'h0002_0000, 32'h0001_0000, 0);
    add_stencil(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    eps_we = 1'b0;
    eps_wdata = '0;
    cell_oldest = '0;
    cell_middle = '0;
    cell_newest = '0;
    eps_shadow = 32'd1;
    mismatches = 0;
    sent = 0;
    stall_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_directed();
    add_random(900);
    // zero epsilon makes flat stencils a zero-denominator case
    settle_and_set_eps(32'd0);
    add_directed();
    add_random(250);
    settle_and_set_eps(32'hffff_ffff);
    add_directed();
    add_random(250);
    settle_and_set_eps($urandom);
    add_random(200);
    settle_and_set_eps(32'd1);
    add_random(200);

    while (stencil_q.size() > 0 || start || faces_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
